/* hdl/chip8_instruction_core_top_defines.svh */
// Assertion macros used by the instruction core controller.
// Expects clk and arst_n in the scope of each use.
`ifndef CHIP8_INSTRUCTION_CORE_TOP_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define C8IC_ASSERT_NOW(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define C8IC_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

/* hdl/c8ic_pkg.sv */
// Types, codes and helper functions of the instruction core.
// No dependencies; used by the datapath, controller and top level of the core.
`default_nettype none

package c8ic_pkg;

	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_EXEC    = 3'd2;
	localparam logic [2:0] OP_TICK    = 3'd3;
	localparam logic [2:0] OP_PIXEL   = 3'd4;
	localparam logic [2:0] OP_RESTART = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_HALTED  = 2'd2;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int PIX_AW        = $clog2(PIXELS);

	localparam logic [11:0] START_PC = 12'h200;
	localparam logic [3:0]  REG_FLAG = 4'hF;

	localparam logic [3:0] MAJ_SYS  = 4'h0;
	localparam logic [3:0] MAJ_JP   = 4'h1;
	localparam logic [3:0] MAJ_CALL = 4'h2;
	localparam logic [3:0] MAJ_SE   = 4'h3;
	localparam logic [3:0] MAJ_SNE  = 4'h4;
	localparam logic [3:0] MAJ_LD   = 4'h6;
	localparam logic [3:0] MAJ_ADD  = 4'h7;
	localparam logic [3:0] MAJ_ALU  = 4'h8;
	localparam logic [3:0] MAJ_LDI  = 4'hA;
	localparam logic [3:0] MAJ_RND  = 4'hC;
	localparam logic [3:0] MAJ_DRW  = 4'hD;
	localparam logic [3:0] MAJ_KEY  = 4'hE;
	localparam logic [3:0] MAJ_MISC = 4'hF;

	localparam logic [11:0] NNN_CLS = 12'h0E0;
	localparam logic [11:0] NNN_RET = 12'h0EE;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] KK_SKP   = 8'hA1;
	localparam logic [7:0] KK_LDDT  = 8'h07;
	localparam logic [7:0] KK_SETDT = 8'h15;
	localparam logic [7:0] KK_SND   = 8'h18;
	localparam logic [7:0] KK_ADDI  = 8'h1E;
	localparam logic [7:0] KK_FONT  = 8'h29;
	localparam logic [7:0] KK_BCD   = 8'h33;
	localparam logic [7:0] KK_STR   = 8'h55;
	localparam logic [7:0] KK_LDM   = 8'h65;

	typedef enum logic [4:0] {
		K_ILL, K_CLS, K_RET, K_JP, K_CALL, K_SE, K_SNE, K_LD, K_ADD,
		K_MOV, K_AND, K_XOR, K_ADDC, K_SUB, K_SHR, K_SHL, K_LDI, K_RND,
		K_DRW, K_SKP, K_LDDT, K_SETDT, K_NOP, K_ADDI, K_FONT, K_BCD,
		K_STR, K_LDM
	} kind_t;

	typedef enum logic [4:0] {
		C_NONE, C_CLR, C_MWR, C_MRD, C_MCAP, C_PRD, C_PCAP, C_TICK,
		C_RST, C_HALTD, C_F1, C_F2, C_F3, C_RX, C_RY, C_EXEC, C_CLS,
		C_DROW, C_DBYT, C_DPIX, C_DPW, C_DFIN, C_BCD, C_STR, C_LDR,
		C_LDW, C_RESP
	} cmd_t;

	typedef struct packed {
		logic take;
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic  halted;
		kind_t kind;
		logic  out_busy;
		logic  clr_last;
		logic  cls_last;
		logic  bcd_last;
		logic  blk_last;
		logic  row_done;
		logic  pix_hit;
		logic  j_last;
	} sts_t;

	function automatic kind_t decode(input logic [15:0] ins);
		kind_t k;
		k = K_ILL;
		case (ins[15:12])
			MAJ_SYS: begin
				if (ins[11:0] == NNN_CLS) k = K_CLS;
				else if (ins[11:0] == NNN_RET) k = K_RET;
			end
			MAJ_JP:   k = K_JP;
			MAJ_CALL: k = K_CALL;
			MAJ_SE:   k = K_SE;
			MAJ_SNE:  k = K_SNE;
			MAJ_LD:   k = K_LD;
			MAJ_ADD:  k = K_ADD;
			MAJ_ALU: begin
				case (ins[3:0])
					ALU_MOV: k = K_MOV;
					ALU_AND: k = K_AND;
					ALU_XOR: k = K_XOR;
					ALU_ADD: k = K_ADDC;
					ALU_SUB: k = K_SUB;
					ALU_SHR: k = K_SHR;
					ALU_SHL: k = K_SHL;
					default: k = K_ILL;
				endcase
			end
			MAJ_LDI: k = K_LDI;
			MAJ_RND: k = K_RND;
			MAJ_DRW: k = K_DRW;
			MAJ_KEY: if (ins[7:0] == KK_SKP) k = K_SKP;
			MAJ_MISC: begin
				case (ins[7:0])
					KK_LDDT:  k = K_LDDT;
					KK_SETDT: k = K_SETDT;
					KK_SND:   k = K_NOP;
					KK_ADDI:  k = K_ADDI;
					KK_FONT:  k = K_FONT;
					KK_BCD:   k = K_BCD;
					KK_STR:   k = K_STR;
					KK_LDM:   k = K_LDM;
					default:  k = K_ILL;
				endcase
			end
			default: k = K_ILL;
		endcase
		return k;
	endfunction

	// sel 0 hundreds, 1 tens, otherwise ones
	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [14:0] m;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
		m = 15'(r) * 15'd205;
		t = m[14:11];
		o = r - 8'({4'd0, t} * 8'd10);
		case (sel)
			2'd0:    return {6'd0, h};
			2'd1:    return {4'd0, t};
			default: return o;
		endcase
	endfunction

endpackage

`default_nettype wire

/* hdl/c8ic_if.sv */
// Valid/ready channels of the instruction core: item beats in, result beats out.
// Payload widths are fixed by the item and result formats.
`default_nettype none

interface c8ic_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic [7:0]  random_byte;
	modport source(output valid, output opcode, output address, output write_data,
		output random_byte, input ready);
	modport sink(input valid, input opcode, input address, input write_data,
		input random_byte, output ready);
endinterface

interface c8ic_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] program_counter;
	logic [1:0]  status;
	logic [7:0]  read_value;
	logic [7:0]  flag_register;
	modport source(output valid, output program_counter, output status,
		output read_value, output flag_register, input ready);
	modport sink(input valid, input program_counter, input status,
		input read_value, input flag_register, output ready);
endinterface

`default_nettype wire

/* hdl/c8ic_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module c8ic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

/* hdl/c8ic_datapath.sv */
// Datapath: architectural registers, memory and display RAMs, result register.
// Depends on c8ic_pkg, c8ic_if and c8ic_ram; driven by c8ic_ctrl commands.
`default_nettype none

module c8ic_datapath #(
	parameter int MEMORY_BYTES = 4096,
	parameter int STACK_DEPTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c8ic_pkg::ctl_t        ctl,
	output c8ic_pkg::sts_t        sts,
	input  logic [11:0]           item_address,
	input  logic [7:0]            item_write_data,
	input  logic [7:0]            item_random_byte,
	c8ic_result_if.source         result
);

	localparam int MAW   = $clog2(MEMORY_BYTES);
	localparam int CLR_N = (MEMORY_BYTES > c8ic_pkg::PIXELS) ? MEMORY_BYTES : c8ic_pkg::PIXELS;
	localparam int CW    = $clog2(CLR_N);
	localparam int SPW   = $clog2(STACK_DEPTH);

	logic [11:0]      addr_q;
	logic [7:0]       wdata_q, rnd_q;
	logic [15:0]      ins_q;
	logic [7:0]       vx_q, vy_q, bits_q;
	c8ic_pkg::kind_t  kind_q;
	logic [CW-1:0]    cnt_q;
	logic [2:0]       j_q;
	logic             off_q;
	logic [1:0]       status_q;
	logic [7:0]       rv_q;
	logic [11:0]      pc_q;
	logic [15:0]      index_q;
	logic [SPW-1:0]   sp_q;
	logic [7:0]       dt_q;
	logic             halted_q;
	logic [7:0]       rf_q [16];
	logic [11:0]      stk_q [STACK_DEPTH];
	logic             res_valid_q;
	logic [11:0]      res_pc_q;
	logic [1:0]       res_status_q;
	logic [7:0]       res_rv_q, res_flag_q;

	logic [3:0]       x, y, rf_raddr;
	logic [7:0]       kk, rf_rdata;
	logic [11:0]      nnn, pc2, pc4, pc1, ex_pc;
	logic [15:0]      ia, pix_p;
	logic [8:0]       row, sum9;
	logic             hit;
	logic [SPW-1:0]   sp_inc, sp_dec;
	logic             ex_rf_we, ex_fl_we;
	logic [7:0]       ex_rf_val, ex_fl_val;
	logic             mem_we, pix_we, pix_wdata, pix_rdata;
	logic [MAW-1:0]   mem_addr;
	logic [7:0]       mem_wdata, mem_rdata;
	logic [c8ic_pkg::PIX_AW-1:0] pix_addr;
	logic             blk_last;

	assign x    = ins_q[11:8];
	assign y    = ins_q[7:4];
	assign kk   = ins_q[7:0];
	assign nnn  = ins_q[11:0];
	assign pc1  = pc_q + 12'd1;
	assign pc2  = pc_q + 12'd2;
	assign pc4  = pc_q + 12'd4;
	assign ia   = index_q + 16'(cnt_q);
	assign row  = {1'b0, vy_q} + {5'd0, cnt_q[3:0]};
	assign pix_p = 16'(vx_q) + 16'(j_q) + {1'b0, row, 6'd0};
	assign hit  = bits_q[~j_q] && (pix_p < 16'(c8ic_pkg::PIXELS));
	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign blk_last = (cnt_q == CW'(x));

	assign rf_raddr = (ctl.cmd == c8ic_pkg::C_RY) ? y :
		((ctl.cmd == c8ic_pkg::C_STR) ? cnt_q[3:0] : x);
	assign rf_rdata = rf_q[rf_raddr];

	assign sts.halted   = halted_q;
	assign sts.kind     = kind_q;
	assign sts.out_busy = res_valid_q && !result.ready;
	assign sts.clr_last = (cnt_q == CW'(CLR_N - 1));
	assign sts.cls_last = (cnt_q == CW'(c8ic_pkg::PIXELS - 1));
	assign sts.bcd_last = (cnt_q == CW'(2));
	assign sts.blk_last = blk_last;
	assign sts.row_done = (cnt_q == CW'(ins_q[3:0]));
	assign sts.pix_hit  = hit;
	assign sts.j_last   = (j_q == 3'd7);

	assign result.valid           = res_valid_q;
	assign result.program_counter = res_pc_q;
	assign result.status          = res_status_q;
	assign result.read_value      = res_rv_q;
	assign result.flag_register   = res_flag_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_q[MAW-1:0];
		mem_wdata = wdata_q;
		pix_we    = 1'b0;
		pix_addr  = addr_q[c8ic_pkg::PIX_AW-1:0];
		pix_wdata = 1'b0;
		case (ctl.cmd)
			c8ic_pkg::C_CLR: begin
				mem_we    = (32'(cnt_q) < 32'(MEMORY_BYTES));
				mem_addr  = cnt_q[MAW-1:0];
				mem_wdata = '0;
				pix_we    = (32'(cnt_q) < 32'(c8ic_pkg::PIXELS));
				pix_addr  = cnt_q[c8ic_pkg::PIX_AW-1:0];
			end
			c8ic_pkg::C_CLS: begin
				pix_we   = 1'b1;
				pix_addr = cnt_q[c8ic_pkg::PIX_AW-1:0];
			end
			c8ic_pkg::C_MWR: mem_we = 1'b1;
			c8ic_pkg::C_F1:  mem_addr = pc_q[MAW-1:0];
			c8ic_pkg::C_F2:  mem_addr = pc1[MAW-1:0];
			c8ic_pkg::C_DROW, c8ic_pkg::C_LDR: mem_addr = ia[MAW-1:0];
			c8ic_pkg::C_BCD: begin
				mem_we    = 1'b1;
				mem_addr  = ia[MAW-1:0];
				mem_wdata = c8ic_pkg::bcd_digit(vx_q, cnt_q[1:0]);
			end
			c8ic_pkg::C_STR: begin
				mem_we    = 1'b1;
				mem_addr  = ia[MAW-1:0];
				mem_wdata = rf_rdata;
			end
			c8ic_pkg::C_DPIX: pix_addr = pix_p[c8ic_pkg::PIX_AW-1:0];
			c8ic_pkg::C_DPW: begin
				pix_we    = 1'b1;
				pix_addr  = pix_p[c8ic_pkg::PIX_AW-1:0];
				pix_wdata = ~pix_rdata;
			end
			default: ;
		endcase
	end

	always_comb begin
		ex_pc     = pc2;
		ex_rf_we  = 1'b0;
		ex_rf_val = '0;
		ex_fl_we  = 1'b0;
		ex_fl_val = '0;
		case (kind_q)
			c8ic_pkg::K_RET:  ex_pc = stk_q[sp_dec];
			c8ic_pkg::K_JP, c8ic_pkg::K_CALL: ex_pc = nnn;
			c8ic_pkg::K_SE:   if (vx_q == kk) ex_pc = pc4;
			c8ic_pkg::K_SNE:  if (vx_q != kk) ex_pc = pc4;
			c8ic_pkg::K_SKP:  ex_pc = pc4;
			c8ic_pkg::K_LD:   begin ex_rf_we = 1'b1; ex_rf_val = kk; end
			c8ic_pkg::K_ADD:  begin ex_rf_we = 1'b1; ex_rf_val = vx_q + kk; end
			c8ic_pkg::K_MOV:  begin ex_rf_we = 1'b1; ex_rf_val = vy_q; end
			c8ic_pkg::K_AND:  begin ex_rf_we = 1'b1; ex_rf_val = vx_q & vy_q; end
			c8ic_pkg::K_XOR:  begin ex_rf_we = 1'b1; ex_rf_val = vx_q ^ vy_q; end
			c8ic_pkg::K_ADDC: begin
				ex_rf_we = 1'b1; ex_rf_val = sum9[7:0];
				ex_fl_we = 1'b1; ex_fl_val = {7'd0, sum9[8]};
			end
			c8ic_pkg::K_SUB: begin
				ex_rf_we = 1'b1; ex_rf_val = vx_q - vy_q;
				ex_fl_we = 1'b1; ex_fl_val = {7'd0, vx_q >= vy_q};
			end
			c8ic_pkg::K_SHR: begin
				ex_rf_we = 1'b1; ex_rf_val = {1'b0, vy_q[7:1]};
				ex_fl_we = 1'b1; ex_fl_val = {7'd0, vy_q[0]};
			end
			c8ic_pkg::K_SHL: begin
				ex_rf_we = 1'b1; ex_rf_val = {vy_q[6:0], 1'b0};
				ex_fl_we = 1'b1; ex_fl_val = {7'd0, vy_q[7]};
			end
			c8ic_pkg::K_RND:  begin ex_rf_we = 1'b1; ex_rf_val = rnd_q & kk; end
			c8ic_pkg::K_LDDT: begin ex_rf_we = 1'b1; ex_rf_val = dt_q; end
			default: ;
		endcase
	end

	c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	c8ic_ram #(.WIDTH(1), .DEPTH(c8ic_pkg::PIXELS)) u_pix (
		.clk(clk), .we(pix_we), .addr(pix_addr), .wdata(pix_wdata), .rdata(pix_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= c8ic_pkg::START_PC;
			index_q     <= '0;
			sp_q        <= '0;
			dt_q        <= '0;
			halted_q    <= 1'b0;
			cnt_q       <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 16; k++) rf_q[k] <= '0;
		end else begin
			if (result.ready && ctl.cmd != c8ic_pkg::C_RESP) res_valid_q <= 1'b0;
			case (ctl.cmd)
				c8ic_pkg::C_CLR, c8ic_pkg::C_CLS, c8ic_pkg::C_BCD: cnt_q <= cnt_q + 1'b1;
				c8ic_pkg::C_TICK: if (dt_q != '0) dt_q <= dt_q - 8'd1;
				c8ic_pkg::C_RST: begin
					pc_q     <= c8ic_pkg::START_PC;
					dt_q     <= '0;
					sp_q     <= '0;
					halted_q <= 1'b0;
				end
				c8ic_pkg::C_EXEC: begin
					cnt_q <= '0;
					j_q   <= '0;
					if (kind_q == c8ic_pkg::K_ILL) halted_q <= 1'b1;
					else pc_q <= ex_pc;
					if (ex_rf_we && !(ex_fl_we && x == c8ic_pkg::REG_FLAG))
						rf_q[x] <= ex_rf_val;
					if (ex_fl_we) rf_q[c8ic_pkg::REG_FLAG] <= ex_fl_val;
					case (kind_q)
						c8ic_pkg::K_RET:   sp_q <= sp_dec;
						c8ic_pkg::K_CALL:  sp_q <= sp_inc;
						c8ic_pkg::K_LDI:   index_q <= {4'd0, nnn};
						c8ic_pkg::K_ADDI:  index_q <= index_q + 16'(vx_q);
						c8ic_pkg::K_FONT:  index_q <= {6'd0, vx_q, 2'd0} + 16'(vx_q);
						c8ic_pkg::K_SETDT: dt_q <= vx_q;
						default: ;
					endcase
				end
				c8ic_pkg::C_DBYT: j_q <= '0;
				c8ic_pkg::C_DPIX: begin
					if (!hit) begin
						j_q <= j_q + 3'd1;
						if (j_q == 3'd7) cnt_q <= cnt_q + 1'b1;
					end
				end
				c8ic_pkg::C_DPW: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd7) cnt_q <= cnt_q + 1'b1;
				end
				c8ic_pkg::C_DFIN: rf_q[c8ic_pkg::REG_FLAG] <= {7'd0, off_q};
				c8ic_pkg::C_STR: begin
					cnt_q <= cnt_q + 1'b1;
					if (blk_last) index_q <= index_q + 16'(x) + 16'd1;
				end
				c8ic_pkg::C_LDW: begin
					cnt_q <= cnt_q + 1'b1;
					rf_q[cnt_q[3:0]] <= mem_rdata;
					if (blk_last) index_q <= index_q + 16'(x) + 16'd1;
				end
				c8ic_pkg::C_RESP: res_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			addr_q   <= item_address;
			wdata_q  <= item_write_data;
			rnd_q    <= item_random_byte;
			status_q <= c8ic_pkg::ST_OK;
			rv_q     <= '0;
		end
		case (ctl.cmd)
			c8ic_pkg::C_MCAP:  rv_q <= mem_rdata;
			c8ic_pkg::C_PCAP:  rv_q <= (addr_q < 12'(c8ic_pkg::PIXELS)) ? {7'd0, pix_rdata} : '0;
			c8ic_pkg::C_HALTD: status_q <= c8ic_pkg::ST_HALTED;
			c8ic_pkg::C_F2:    ins_q[15:8] <= mem_rdata;
			c8ic_pkg::C_F3:    ins_q[7:0] <= mem_rdata;
			c8ic_pkg::C_RX:    vx_q <= rf_rdata;
			c8ic_pkg::C_RY: begin
				vy_q   <= rf_rdata;
				kind_q <= c8ic_pkg::decode(ins_q);
			end
			c8ic_pkg::C_EXEC: begin
				off_q <= 1'b0;
				if (kind_q == c8ic_pkg::K_ILL) status_q <= c8ic_pkg::ST_ILLEGAL;
				if (kind_q == c8ic_pkg::K_CALL) stk_q[sp_q] <= pc2;
			end
			c8ic_pkg::C_DBYT: bits_q <= mem_rdata;
			c8ic_pkg::C_DPW:  if (pix_rdata) off_q <= 1'b1;
			c8ic_pkg::C_RESP: begin
				res_pc_q     <= pc_q;
				res_status_q <= status_q;
				res_rv_q     <= rv_q;
				res_flag_q   <= rf_q[c8ic_pkg::REG_FLAG];
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/c8ic_ctrl.sv */
// Controller: sequences item handling and instruction execution as datapath commands.
// Depends on c8ic_pkg and the assertion macro header.
`default_nettype none
`include "chip8_instruction_core_top_defines.svh"

module c8ic_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic [2:0]     item_opcode,
	output logic           ready,
	input  c8ic_pkg::sts_t sts,
	output c8ic_pkg::ctl_t ctl
);

	typedef enum logic [26:0] {
		S_CLR   = 27'd1 << 0,
		S_IDLE  = 27'd1 << 1,
		S_MWR   = 27'd1 << 2,
		S_MRD   = 27'd1 << 3,
		S_MCAP  = 27'd1 << 4,
		S_PRD   = 27'd1 << 5,
		S_PCAP  = 27'd1 << 6,
		S_TICK  = 27'd1 << 7,
		S_RST   = 27'd1 << 8,
		S_HALTD = 27'd1 << 9,
		S_F1    = 27'd1 << 10,
		S_F2    = 27'd1 << 11,
		S_F3    = 27'd1 << 12,
		S_RX    = 27'd1 << 13,
		S_RY    = 27'd1 << 14,
		S_EXEC  = 27'd1 << 15,
		S_CLS   = 27'd1 << 16,
		S_DROW  = 27'd1 << 17,
		S_DBYT  = 27'd1 << 18,
		S_DPIX  = 27'd1 << 19,
		S_DPW   = 27'd1 << 20,
		S_DFIN  = 27'd1 << 21,
		S_BCD   = 27'd1 << 22,
		S_STR   = 27'd1 << 23,
		S_LDR   = 27'd1 << 24,
		S_LDW   = 27'd1 << 25,
		S_RESP  = 27'd1 << 26
	} state_t;

	state_t state_q, state_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		ctl.take = ready && item_valid;
		ctl.cmd  = c8ic_pkg::C_NONE;
		case (state_q)
			S_CLR: begin
				ctl.cmd = c8ic_pkg::C_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					case (item_opcode)
						c8ic_pkg::OP_WRITE:   state_d = S_MWR;
						c8ic_pkg::OP_READ:    state_d = S_MRD;
						c8ic_pkg::OP_EXEC:    state_d = sts.halted ? S_HALTD : S_F1;
						c8ic_pkg::OP_TICK:    state_d = S_TICK;
						c8ic_pkg::OP_PIXEL:   state_d = S_PRD;
						c8ic_pkg::OP_RESTART: state_d = S_RST;
						default:              state_d = S_RESP;
					endcase
				end
			end
			S_MWR:   begin ctl.cmd = c8ic_pkg::C_MWR;   state_d = S_RESP; end
			S_MRD:   begin ctl.cmd = c8ic_pkg::C_MRD;   state_d = S_MCAP; end
			S_MCAP:  begin ctl.cmd = c8ic_pkg::C_MCAP;  state_d = S_RESP; end
			S_PRD:   begin ctl.cmd = c8ic_pkg::C_PRD;   state_d = S_PCAP; end
			S_PCAP:  begin ctl.cmd = c8ic_pkg::C_PCAP;  state_d = S_RESP; end
			S_TICK:  begin ctl.cmd = c8ic_pkg::C_TICK;  state_d = S_RESP; end
			S_RST:   begin ctl.cmd = c8ic_pkg::C_RST;   state_d = S_RESP; end
			S_HALTD: begin ctl.cmd = c8ic_pkg::C_HALTD; state_d = S_RESP; end
			S_F1:    begin ctl.cmd = c8ic_pkg::C_F1;    state_d = S_F2; end
			S_F2:    begin ctl.cmd = c8ic_pkg::C_F2;    state_d = S_F3; end
			S_F3:    begin ctl.cmd = c8ic_pkg::C_F3;    state_d = S_RX; end
			S_RX:    begin ctl.cmd = c8ic_pkg::C_RX;    state_d = S_RY; end
			S_RY:    begin ctl.cmd = c8ic_pkg::C_RY;    state_d = S_EXEC; end
			S_EXEC: begin
				ctl.cmd = c8ic_pkg::C_EXEC;
				case (sts.kind)
					c8ic_pkg::K_CLS: state_d = S_CLS;
					c8ic_pkg::K_DRW: state_d = S_DROW;
					c8ic_pkg::K_BCD: state_d = S_BCD;
					c8ic_pkg::K_STR: state_d = S_STR;
					c8ic_pkg::K_LDM: state_d = S_LDR;
					default:         state_d = S_RESP;
				endcase
			end
			S_CLS: begin
				ctl.cmd = c8ic_pkg::C_CLS;
				if (sts.cls_last) state_d = S_RESP;
			end
			S_DROW: begin
				ctl.cmd = c8ic_pkg::C_DROW;
				state_d = sts.row_done ? S_DFIN : S_DBYT;
			end
			S_DBYT: begin ctl.cmd = c8ic_pkg::C_DBYT; state_d = S_DPIX; end
			S_DPIX: begin
				ctl.cmd = c8ic_pkg::C_DPIX;
				if (sts.pix_hit) state_d = S_DPW;
				else if (sts.j_last) state_d = S_DROW;
			end
			S_DPW: begin
				ctl.cmd = c8ic_pkg::C_DPW;
				state_d = sts.j_last ? S_DROW : S_DPIX;
			end
			S_DFIN: begin ctl.cmd = c8ic_pkg::C_DFIN; state_d = S_RESP; end
			S_BCD: begin
				ctl.cmd = c8ic_pkg::C_BCD;
				if (sts.bcd_last) state_d = S_RESP;
			end
			S_STR: begin
				ctl.cmd = c8ic_pkg::C_STR;
				if (sts.blk_last) state_d = S_RESP;
			end
			S_LDR: begin ctl.cmd = c8ic_pkg::C_LDR; state_d = S_LDW; end
			S_LDW: begin
				ctl.cmd = c8ic_pkg::C_LDW;
				state_d = sts.blk_last ? S_RESP : S_LDR;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					ctl.cmd = c8ic_pkg::C_RESP;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	`C8IC_ASSERT_NEXT(a_take_leaves_idle, ctl.take, state_q != S_IDLE, "beat taken but still idle")
	`C8IC_ASSERT_NOW(a_no_take_in_clear, state_q == S_CLR, !ready, "ready during clearing pass")
	`C8IC_ASSERT_NEXT(a_resp_to_idle, (state_q == S_RESP) && !sts.out_busy, state_q == S_IDLE,
		"result loaded but no return to idle")
	`C8IC_ASSERT_NOW(a_no_exec_halted, ctl.cmd == c8ic_pkg::C_EXEC, !sts.halted,
		"instruction executed while halted")

endmodule

`default_nettype wire

/* hdl/chip8_instruction_core_top.sv */
// Top level of the instruction core: controller, datapath and the two channels.
// Depends on c8ic_pkg, c8ic_if, c8ic_ram, c8ic_datapath and c8ic_ctrl.
//
// One item in, one result out, one item at a time. After reset the core sweeps memory
// and display to zero with item ready low. MEMORY_BYTES must be a power of two.
// An executed instruction makes two fetch reads and two register reads through the
// single ports before it executes; clear screen, BCD, Fx55, Fx65 and draw then step
// through their own states, each lit pixel of a draw costing a read and a write of
// the display RAM. A result waits in an output register.
`default_nettype none

module chip8_instruction_core_top #(
	parameter int MEMORY_BYTES = 4096,
	parameter int STACK_DEPTH  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	c8ic_item_if.sink      item,
	c8ic_result_if.source  result
);

	c8ic_pkg::ctl_t ctl;
	c8ic_pkg::sts_t sts;

	c8ic_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_opcode(item.opcode),
		.ready(item.ready),
		.sts(sts),
		.ctl(ctl)
	);

	c8ic_datapath #(.MEMORY_BYTES(MEMORY_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sts(sts),
		.item_address(item.address),
		.item_write_data(item.write_data),
		.item_random_byte(item.random_byte),
		.result(result)
	);

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for chip8_instruction_core_top: item beats drive a small
// instruction-set core, and each result beat is checked against a behavioural core.
// Depends on c8ic_pkg, c8ic_if and the core RTL.
`default_nettype none

module tb;

	localparam int MEM_BYTES  = 4096;
	localparam int STK_DEPTH  = 16;
	localparam int ITEM_COUNT = 1650;
	localparam int STALL_MAX  = 20000;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] addr;
		logic [7:0]  wdata;
		logic [7:0]  rnd;
	} core_item_t;

	typedef struct packed {
		logic [11:0] pc;
		logic [1:0]  status;
		logic [7:0]  rdata;
		logic [7:0]  vf;
	} core_result_t;

	logic clk;
	logic arst_n;

	c8ic_item_if   item_ch();
	c8ic_result_if res_ch();

	chip8_instruction_core_top #(.MEMORY_BYTES(MEM_BYTES), .STACK_DEPTH(STK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch)
	);

	// behavioural copy of the core
	logic [7:0]  c_mem [MEM_BYTES];
	logic        c_pix [c8ic_pkg::PIXELS];
	logic [7:0]  c_v [16];
	logic [15:0] c_idx;
	logic [11:0] c_pc;
	logic [11:0] c_stk [STK_DEPTH];
	logic        c_stk_set [STK_DEPTH];
	logic [3:0]  c_sp;
	logic [7:0]  c_dt;
	logic        c_halted;

	core_item_t   item_beats [$];
	core_result_t due_results [$];
	int           errors;
	int           sent;
	int           send_idle;
	int           recv_idle;
	int           quiet_cycles;
	logic         item_taken;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = c8ic_pkg::OP_WRITE;
		item_ch.address = '0;
		item_ch.write_data = '0;
		item_ch.random_byte = '0;
		res_ch.ready = 1'b0;
		item_taken = 1'b0;
		errors = 0;
		sent = 0;
		send_idle = 37;
		recv_idle = 49;
		quiet_cycles = 0;
	end

	always #5 clk = ~clk;

	function automatic logic [3:0] sp_below(input logic [3:0] sp);
		return 4'((int'(sp) + STK_DEPTH - 1) % STK_DEPTH);
	endfunction

	// returns 1 on an illegal instruction
	function automatic logic run_instruction(input logic [7:0] rnd);
		logic [15:0] ins;
		logic [3:0]  x, y;
		logic [7:0]  kk, vx, vy, bits;
		logic [11:0] nnn, nxt;
		logic [8:0]  sum;
		logic        off;
		int          p;
		ins = {c_mem[c_pc], c_mem[c_pc + 12'd1]};
		x = ins[11:8];
		y = ins[7:4];
		kk = ins[7:0];
		nnn = ins[11:0];
		nxt = c_pc + 12'd2;
		vx = c_v[x];
		vy = c_v[y];
		case (ins[15:12])
			c8ic_pkg::MAJ_SYS: begin
				if (nnn == c8ic_pkg::NNN_CLS) begin
					for (int i = 0; i < c8ic_pkg::PIXELS; i++) c_pix[i] = 1'b0;
				end else if (nnn == c8ic_pkg::NNN_RET) begin
					c_sp = sp_below(c_sp);
					nxt = c_stk[c_sp];
				end else return 1'b1;
			end
			c8ic_pkg::MAJ_JP: nxt = nnn;
			c8ic_pkg::MAJ_CALL: begin
				c_stk[c_sp] = nxt;
				c_stk_set[c_sp] = 1'b1;
				c_sp = 4'((int'(c_sp) + 1) % STK_DEPTH);
				nxt = nnn;
			end
			c8ic_pkg::MAJ_SE:  if (vx == kk) nxt = nxt + 12'd2;
			c8ic_pkg::MAJ_SNE: if (vx != kk) nxt = nxt + 12'd2;
			c8ic_pkg::MAJ_LD:  c_v[x] = kk;
			c8ic_pkg::MAJ_ADD: c_v[x] = vx + kk;
			c8ic_pkg::MAJ_ALU: begin
				case (ins[3:0])
					c8ic_pkg::ALU_MOV: c_v[x] = vy;
					c8ic_pkg::ALU_AND: c_v[x] = vx & vy;
					c8ic_pkg::ALU_XOR: c_v[x] = vx ^ vy;
					c8ic_pkg::ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						c_v[x] = sum[7:0];
						c_v[c8ic_pkg::REG_FLAG] = {7'd0, sum[8]};
					end
					c8ic_pkg::ALU_SUB: begin
						c_v[x] = vx - vy;
						c_v[c8ic_pkg::REG_FLAG] = {7'd0, vx >= vy};
					end
					c8ic_pkg::ALU_SHR: begin
						c_v[x] = vy >> 1;
						c_v[c8ic_pkg::REG_FLAG] = {7'd0, vy[0]};
					end
					c8ic_pkg::ALU_SHL: begin
						c_v[x] = vy << 1;
						c_v[c8ic_pkg::REG_FLAG] = {7'd0, vy[7]};
					end
					default: return 1'b1;
				endcase
			end
			c8ic_pkg::MAJ_LDI: c_idx = {4'd0, nnn};
			c8ic_pkg::MAJ_RND: c_v[x] = rnd & kk;
			c8ic_pkg::MAJ_DRW: begin
				off = 1'b0;
				for (int i = 0; i < int'(ins[3:0]); i++) begin
					bits = c_mem[12'(c_idx + 16'(i))];
					for (int j = 0; j < 8; j++) begin
						p = int'(vx) + j + (int'(vy) + i) * c8ic_pkg::SCREEN_WIDTH;
						if (p < c8ic_pkg::PIXELS && bits[7 - j]) begin
							c_pix[p] = ~c_pix[p];
							if (!c_pix[p]) off = 1'b1;
						end
					end
				end
				c_v[c8ic_pkg::REG_FLAG] = {7'd0, off};
			end
			c8ic_pkg::MAJ_KEY: begin
				if (kk == c8ic_pkg::KK_SKP) nxt = nxt + 12'd2;
				else return 1'b1;
			end
			c8ic_pkg::MAJ_MISC: begin
				case (kk)
					c8ic_pkg::KK_LDDT:  c_v[x] = c_dt;
					c8ic_pkg::KK_SETDT: c_dt = vx;
					c8ic_pkg::KK_SND:   ;
					c8ic_pkg::KK_ADDI:  c_idx = c_idx + {8'd0, vx};
					c8ic_pkg::KK_FONT:  c_idx = {8'd0, vx} * 16'd5;
					c8ic_pkg::KK_BCD: begin
						c_mem[12'(c_idx)] = vx / 8'd100;
						c_mem[12'(c_idx + 16'd1)] = (vx / 8'd10) % 8'd10;
						c_mem[12'(c_idx + 16'd2)] = vx % 8'd10;
					end
					c8ic_pkg::KK_STR: begin
						for (int i = 0; i <= int'(x); i++) c_mem[12'(c_idx + 16'(i))] = c_v[i];
						c_idx = c_idx + {12'd0, x} + 16'd1;
					end
					c8ic_pkg::KK_LDM: begin
						for (int i = 0; i <= int'(x); i++) c_v[i] = c_mem[12'(c_idx + 16'(i))];
						c_idx = c_idx + {12'd0, x} + 16'd1;
					end
					default: return 1'b1;
				endcase
			end
			default: return 1'b1;
		endcase
		c_pc = nxt;
		return 1'b0;
	endfunction

	function automatic core_result_t core_step(input core_item_t it);
		core_result_t r;
		r = '0;
		case (it.op)
			c8ic_pkg::OP_WRITE: c_mem[it.addr] = it.wdata;
			c8ic_pkg::OP_READ:  r.rdata = c_mem[it.addr];
			c8ic_pkg::OP_EXEC: begin
				if (c_halted) r.status = c8ic_pkg::ST_HALTED;
				else if (run_instruction(it.rnd)) begin
					c_halted = 1'b1;
					r.status = c8ic_pkg::ST_ILLEGAL;
				end
			end
			c8ic_pkg::OP_TICK:  if (c_dt != 8'd0) c_dt = c_dt - 8'd1;
			c8ic_pkg::OP_PIXEL: r.rdata = (int'(it.addr) < c8ic_pkg::PIXELS) ?
				{7'd0, c_pix[it.addr]} : 8'd0;
			c8ic_pkg::OP_RESTART: begin
				c_pc = c8ic_pkg::START_PC;
				c_dt = '0;
				c_sp = '0;
				c_halted = 1'b0;
			end
			default: ;
		endcase
		r.pc = c_pc;
		r.vf = c_v[c8ic_pkg::REG_FLAG];
		return r;
	endfunction

	function automatic void queue_beat(input core_item_t it);
		item_beats.push_back(it);
		due_results.push_back(core_step(it));
	endfunction

	function automatic void send(input logic [2:0] op, input logic [11:0] addr,
		input logic [7:0] wdata, input logic [7:0] rnd);
		core_item_t it;
		it = '{op, addr, wdata, rnd};
		// a return through a never-written stack slot reads an unset entry: patch it into an LD
		if (op == c8ic_pkg::OP_EXEC && !c_halted && c_mem[c_pc] == c8ic_pkg::NNN_RET[11:8]
			&& c_mem[c_pc + 12'd1] == c8ic_pkg::NNN_RET[7:0] && !c_stk_set[sp_below(c_sp)])
			queue_beat('{c8ic_pkg::OP_WRITE, c_pc, {c8ic_pkg::MAJ_LD, 4'd0}, 8'd0});
		queue_beat(it);
	endfunction

	function automatic void run_ins(input logic [15:0] ins, input logic [7:0] rnd);
		send(c8ic_pkg::OP_WRITE, c_pc, ins[15:8], 8'd0);
		send(c8ic_pkg::OP_WRITE, c_pc + 12'd1, ins[7:0], 8'd0);
		send(c8ic_pkg::OP_EXEC, 12'(($urandom)), 8'($urandom), rnd);
	endfunction

	function automatic logic [15:0] random_ins();
		logic [3:0] x, y, n;
		logic [7:0] kk;
		logic [3:0] alu [7];
		x = 4'($urandom);
		y = 4'($urandom);
		kk = 8'($urandom);
		n = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
		alu = '{c8ic_pkg::ALU_MOV, c8ic_pkg::ALU_AND, c8ic_pkg::ALU_XOR, c8ic_pkg::ALU_ADD,
			c8ic_pkg::ALU_SUB, c8ic_pkg::ALU_SHR, c8ic_pkg::ALU_SHL};
		case ($urandom_range(0, 21))
			0:  return ($urandom_range(15) == 0) ? {c8ic_pkg::MAJ_SYS, c8ic_pkg::NNN_CLS} :
				{c8ic_pkg::MAJ_LD, x, kk};
			1:  return c_stk_set[sp_below(c_sp)] ? {c8ic_pkg::MAJ_SYS, c8ic_pkg::NNN_RET} :
				{c8ic_pkg::MAJ_ADD, x, kk};
			2:  return {c8ic_pkg::MAJ_JP, 12'($urandom)};
			3:  return {c8ic_pkg::MAJ_CALL, 12'($urandom)};
			4:  return {c8ic_pkg::MAJ_SE, x, $urandom_range(1) ? c_v[x] : kk};
			5:  return {c8ic_pkg::MAJ_SNE, x, $urandom_range(1) ? c_v[x] : kk};
			6:  return {c8ic_pkg::MAJ_LD, x, kk};
			7:  return {c8ic_pkg::MAJ_ADD, x, kk};
			8:  return {c8ic_pkg::MAJ_ALU, x, y, alu[$urandom_range(0, 6)]};
			9:  return {c8ic_pkg::MAJ_LDI, 12'($urandom)};
			10: return {c8ic_pkg::MAJ_RND, x, kk};
			11: return {c8ic_pkg::MAJ_DRW, x, y, n};
			12: return {c8ic_pkg::MAJ_KEY, x, c8ic_pkg::KK_SKP};
			13: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_LDDT};
			14: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_SETDT};
			15: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_SND};
			16: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_ADDI};
			17: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_FONT};
			18: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_BCD};
			19: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_STR};
			20: return {c8ic_pkg::MAJ_MISC, x, c8ic_pkg::KK_LDM};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
		$display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < MEM_BYTES; i++) c_mem[i] = '0;
		for (int i = 0; i < c8ic_pkg::PIXELS; i++) c_pix[i] = 1'b0;
		for (int i = 0; i < 16; i++) c_v[i] = '0;
		for (int i = 0; i < STK_DEPTH; i++) begin
			c_stk[i] = '0;
			c_stk_set[i] = 1'b0;
		end
		c_idx = '0;
		c_pc = c8ic_pkg::START_PC;
		c_sp = '0;
		c_dt = '0;
		c_halted = 1'b0;

		run_ins({c8ic_pkg::MAJ_LD, 4'h0, 8'hFF}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LD, 4'h1, 8'h01}, 8'h00);
		run_ins({c8ic_pkg::MAJ_ALU, 4'h0, 4'h1, c8ic_pkg::ALU_ADD}, 8'h00);
		run_ins({c8ic_pkg::MAJ_ALU, 4'hF, 4'h1, c8ic_pkg::ALU_ADD}, 8'h00);
		run_ins({c8ic_pkg::MAJ_ALU, 4'h0, 4'h1, c8ic_pkg::ALU_SUB}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LD, 4'h2, 8'hFF}, 8'h00);
		run_ins({c8ic_pkg::MAJ_ALU, 4'h3, 4'h2, c8ic_pkg::ALU_SHR}, 8'h00);
		run_ins({c8ic_pkg::MAJ_ALU, 4'h3, 4'h2, c8ic_pkg::ALU_SHL}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LDI, 12'hFFE}, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'h2, c8ic_pkg::KK_BCD}, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'h2, c8ic_pkg::KK_FONT}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LDI, 12'h000}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LD, 4'h4, 8'd60}, 8'h00);
		run_ins({c8ic_pkg::MAJ_LD, 4'h5, 8'd30}, 8'h00);
		run_ins({c8ic_pkg::MAJ_DRW, 4'h4, 4'h5, 4'hF}, 8'h00);
		run_ins({c8ic_pkg::MAJ_DRW, 4'h4, 4'h5, 4'hF}, 8'h00);
		send(c8ic_pkg::OP_PIXEL, 12'd2047, 8'h00, 8'h00);
		send(c8ic_pkg::OP_PIXEL, 12'hFFF, 8'h00, 8'h00);
		run_ins({c8ic_pkg::MAJ_SYS, c8ic_pkg::NNN_CLS}, 8'h00);
		run_ins({c8ic_pkg::MAJ_CALL, 12'h300}, 8'h00);
		run_ins({c8ic_pkg::MAJ_SYS, c8ic_pkg::NNN_RET}, 8'h00);
		run_ins({c8ic_pkg::MAJ_KEY, 4'h0, c8ic_pkg::KK_SKP}, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'h2, c8ic_pkg::KK_SETDT}, 8'h00);
		send(c8ic_pkg::OP_TICK, 12'h000, 8'h00, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'h6, c8ic_pkg::KK_LDDT}, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'hF, c8ic_pkg::KK_STR}, 8'h00);
		run_ins({c8ic_pkg::MAJ_MISC, 4'hF, c8ic_pkg::KK_LDM}, 8'h00);
		run_ins({c8ic_pkg::MAJ_RND, 4'h7, 8'hFF}, 8'hA5);
		run_ins(16'h5000, 8'h00);
		send(c8ic_pkg::OP_EXEC, 12'h000, 8'h00, 8'h00);
		send(c8ic_pkg::OP_READ, 12'hFFF, 8'h00, 8'h00);
		send(3'd7, 12'hFFF, 8'hFF, 8'hFF);
		send(c8ic_pkg::OP_RESTART, 12'h000, 8'h00, 8'h00);

		while (item_beats.size() + sent < ITEM_COUNT) begin
			if (c_halted && $urandom_range(1)) begin
				send(c8ic_pkg::OP_RESTART, 12'($urandom), 8'($urandom), 8'($urandom));
				continue;
			end
			case ($urandom_range(0, 99)) inside
				[0:59]:  run_ins(random_ins(), 8'($urandom));
				[60:64]: send(c8ic_pkg::OP_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
				[65:71]: send(c8ic_pkg::OP_WRITE, 12'($urandom), 8'($urandom), 8'($urandom));
				[72:77]: send(c8ic_pkg::OP_READ, 12'($urandom), 8'($urandom), 8'($urandom));
				[78:82]: send(c8ic_pkg::OP_TICK, 12'($urandom), 8'($urandom), 8'($urandom));
				[83:89]: send(c8ic_pkg::OP_PIXEL, $urandom_range(7) == 0 ? 12'($urandom) :
					12'($urandom_range(0, c8ic_pkg::PIXELS - 1)), 8'($urandom), 8'($urandom));
				[90:92]: send(c8ic_pkg::OP_RESTART, 12'($urandom), 8'($urandom),
					8'($urandom));
				[93:96]: send(3'($urandom_range(6, 7)), 12'($urandom), 8'($urandom),
					8'($urandom));
				default: send(c8ic_pkg::OP_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (item_beats.size() == 0);
		wait (due_results.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	// driver
	always @(posedge clk) item_taken <= item_ch.valid && item_ch.ready;

	always @(negedge clk) begin
		if (arst_n) begin
			if (sent < ITEM_COUNT / 3) begin
				send_idle <= 37;
				recv_idle <= 49;
			end else if (sent < 2 * ITEM_COUNT / 3) begin
				send_idle <= 49;
				recv_idle <= 37;
			end else begin
				send_idle <= 0;
				recv_idle <= 0;
			end
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
			if (!item_ch.valid || item_taken) begin
				if (item_beats.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					item_ch.valid <= 1'b1;
					item_ch.opcode <= item_beats[0].op;
					item_ch.address <= item_beats[0].addr;
					item_ch.write_data <= item_beats[0].wdata;
					item_ch.random_byte <= item_beats[0].rnd;
					void'(item_beats.pop_front());
					sent <= sent + 1;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		core_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					report("unexpected result beat", res_ch.program_counter, 12'd0);
				end else begin
					want = due_results.pop_front();
					if (res_ch.program_counter !== want.pc)
						report("program_counter", res_ch.program_counter, want.pc);
					if (res_ch.status !== want.status)
						report("status", 12'(res_ch.status), 12'(want.status));
					if (res_ch.read_value !== want.rdata)
						report("read_value", 12'(res_ch.read_value), 12'(want.rdata));
					if (res_ch.flag_register !== want.vf)
						report("flag_register", 12'(res_ch.flag_register), 12'(want.vf));
				end
			end
			if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/c8ic_pkg.sv
hdl/c8ic_if.sv
hdl/c8ic_ram.sv
hdl/c8ic_datapath.sv
hdl/c8ic_ctrl.sv
hdl/chip8_instruction_core_top.sv
verif/tb.sv
